[rtl/bba_pkg.sv]
// shared types and constants for the buddy block allocator
package bba_pkg;

  localparam int OP_W     = 1;
  localparam int SIZE_W   = 17;
  localparam int OFFS_W   = 16;
  localparam int STATUS_W = 2;
  localparam int ORDER_W  = 4;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SIZE_W-1:0] request_size;
    logic [OFFS_W-1:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFS_W-1:0]   granted_offset;
    logic [ORDER_W-1:0]  granted_order;
  } rsp_t;

endpackage

[rtl/bba_req_if.sv]
// valid/ready channel carrying one request item
interface bba_req_if;
  import bba_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/bba_rsp_if.sv]
// valid/ready channel carrying one result item
interface bba_rsp_if;
  import bba_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/buddy_block_allocator_unit.sv]
// buddy block allocator: header memory, scan/split/merge sequencer
//
// Usage: requests arrive on in_req (operation, request_size, block_offset),
// results leave on out_rsp (status, granted_offset, granted_order), one
// result item per request item. in_req.ready is high only when the sequencer
// is idle and no result is pending.
// Sequencing: the header memory has one read port with registered data, so
// each header visit takes a read state and a check state. An allocate first
// finds the order that holds the request, then scans block heads order by
// order and splits one level per cycle; a free reads and checks its head, then
// per merge level reads the buddy, checks it and writes the merged head. A
// worst case allocate scan visits up to POOL_UNITS heads per order.
// Reset: a clearing pass writes every header entry, one per cycle, setting
// head zero free at the maximum order and clearing the others; no item is
// accepted during the pass.
// Stall: a result holds in its output register until out_rsp.ready; the
// block accepts nothing further meanwhile.
module buddy_block_allocator_unit #(
  parameter int UNIT_BYTES = 64,
  parameter int POOL_UNITS = 1024
) (
  input logic clk,
  input logic rst_n,
  bba_req_if.sink   in_req,
  bba_rsp_if.source out_rsp
);
  import bba_pkg::*;

  localparam int MAXO   = $clog2(POOL_UNITS + 1) - 1;
  localparam int SPAN   = 1 << MAXO;
  localparam int IDX_W  = (MAXO < 1) ? 1 : MAXO;
  localparam int CNT_W  = IDX_W + 1;
  localparam int UB_SH  = $clog2(UNIT_BYTES);
  localparam int HDR_W  = ORDER_W + 1;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SIZE   = 4'd2;
  localparam logic [3:0] S_SRD    = 4'd3;
  localparam logic [3:0] S_SCHK   = 4'd4;
  localparam logic [3:0] S_SPLIT  = 4'd5;
  localparam logic [3:0] S_FRD    = 4'd6;
  localparam logic [3:0] S_FCHK   = 4'd7;
  localparam logic [3:0] S_BRD    = 4'd8;
  localparam logic [3:0] S_BCHK   = 4'd9;
  localparam logic [3:0] S_MRG    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  // header memory: {used, order}
  logic [HDR_W-1:0] hdr_mem [SPAN];
  logic [HDR_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  logic [HDR_W-1:0] wr_data;

  logic [3:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [ORDER_W-1:0]  k_r, k_nxt;
  logic [ORDER_W-1:0]  o_r, o_nxt;
  logic [ORDER_W-1:0]  mo_r, mo_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [OFFS_W-1:0]   boff_r, boff_nxt;
  logic                out_valid_r, out_valid_nxt;
  rsp_t                out_r, out_nxt;

  logic [ORDER_W-1:0]  hdr_o;
  logic                hdr_u;
  logic [ORDER_W-1:0]  step_o;
  logic [CNT_W-1:0]    step_v;
  logic [CNT_W-1:0]    bud_v;
  logic [IDX_W-1:0]    idx_lo;
  logic [SIZE_W+16:0]  cap;

  assign hdr_o  = rd_data_r[ORDER_W-1:0];
  assign hdr_u  = rd_data_r[ORDER_W];
  assign idx_lo = idx_r[IDX_W-1:0];

  // memory port
  always_ff @(posedge clk) begin
    if (we) begin
      hdr_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= hdr_mem[rd_addr];
  end

  // shared shift/compare terms
  always_comb begin
    step_o = (hdr_o > o_r) ? hdr_o : o_r;
    if (step_o > ORDER_W'(MAXO)) step_o = ORDER_W'(MAXO);
    step_v = CNT_W'(1) << step_o;
    bud_v  = idx_r ^ (CNT_W'(1) << mo_r);
    cap    = (SIZE_W+17)'(UNIT_BYTES) << k_r;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    o_nxt         = o_r;
    mo_nxt        = mo_r;
    size_nxt      = size_r;
    boff_nxt      = boff_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    rd_addr       = idx_lo;
    we            = 1'b0;
    wr_addr       = idx_lo;
    wr_data       = '0;
    unique case (state_r)
      S_CLR: begin
        we      = 1'b1;
        wr_data = (idx_r == '0) ? HDR_W'(MAXO) : '0;
        if (idx_r == CNT_W'(SPAN - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (in_req.valid) begin
          size_nxt = in_req.data.request_size;
          boff_nxt = in_req.data.block_offset;
          k_nxt    = '0;
          out_nxt  = '0;
          state_nxt = (in_req.data.operation == OP_ALLOC) ? S_SIZE : S_FRD;
        end
      end
      S_SIZE: begin
        // one order per cycle until the block holds the request
        if (cap >= (SIZE_W+17)'(size_r)) begin
          o_nxt     = k_r;
          idx_nxt   = '0;
          state_nxt = S_SRD;
        end else if (k_r == ORDER_W'(MAXO)) begin
          out_nxt.status = ST_NO_SPACE;
          state_nxt      = S_OUT;
        end else begin
          k_nxt = k_r + ORDER_W'(1);
        end
      end
      S_SRD: begin
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (hdr_o == o_r && !hdr_u) begin
          mo_nxt    = o_r;
          state_nxt = S_SPLIT;
        end else if (idx_r + step_v >= CNT_W'(SPAN)) begin
          if (o_r == ORDER_W'(MAXO)) begin
            out_nxt.status = ST_NO_SPACE;
            state_nxt      = S_OUT;
          end else begin
            o_nxt     = o_r + ORDER_W'(1);
            idx_nxt   = '0;
            state_nxt = S_SRD;
          end
        end else begin
          idx_nxt   = idx_r + step_v;
          state_nxt = S_SRD;
        end
      end
      S_SPLIT: begin
        // write upper half head each cycle; finally mark lower head used
        we = 1'b1;
        if (mo_r > k_r) begin
          wr_addr = IDX_W'(idx_r + (CNT_W'(1) << (mo_r - ORDER_W'(1))));
          wr_data = {1'b0, mo_r - ORDER_W'(1)};
          mo_nxt  = mo_r - ORDER_W'(1);
        end else begin
          wr_data = {1'b1, k_r};
          out_nxt.granted_offset = OFFS_W'(idx_r) << UB_SH;
          out_nxt.granted_order  = k_r;
          out_nxt.status         = ST_OK;
          state_nxt = S_OUT;
        end
      end
      S_FRD: begin
        idx_nxt = CNT_W'(boff_r >> UB_SH);
        rd_addr = IDX_W'(boff_r >> UB_SH);
        if ((boff_r & OFFS_W'(UNIT_BYTES - 1)) != '0 ||
            (OFFS_W+1)'(boff_r >> UB_SH) >= (OFFS_W+1)'(SPAN)) begin
          out_nxt.status = ST_BAD_FREE;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (!hdr_u) begin
          out_nxt.status = ST_BAD_FREE;
          state_nxt      = S_OUT;
        end else begin
          we        = 1'b1;
          wr_data   = {1'b0, hdr_o};
          mo_nxt    = hdr_o;
          state_nxt = S_BRD;
        end
      end
      S_BRD: begin
        if (mo_r >= ORDER_W'(MAXO)) begin
          out_nxt.granted_offset = OFFS_W'(idx_r) << UB_SH;
          out_nxt.granted_order  = mo_r;
          state_nxt = S_OUT;
        end else begin
          rd_addr   = IDX_W'(bud_v);
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (hdr_u || hdr_o != mo_r) begin
          out_nxt.granted_offset = OFFS_W'(idx_r) << UB_SH;
          out_nxt.granted_order  = mo_r;
          state_nxt = S_OUT;
        end else begin
          // clear upper header
          we        = 1'b1;
          wr_addr   = IDX_W'((idx_r > bud_v) ? idx_r : bud_v);
          wr_data   = '0;
          state_nxt = S_MRG;
        end
      end
      S_MRG: begin
        we      = 1'b1;
        wr_addr = IDX_W'(idx_r & bud_v);
        wr_data = {1'b0, mo_r + ORDER_W'(1)};
        idx_nxt = idx_r & bud_v;
        mo_nxt  = mo_r + ORDER_W'(1);
        state_nxt = S_BRD;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        if (out_valid_r && out_rsp.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r    <= k_nxt;
    o_r    <= o_nxt;
    mo_r   <= mo_nxt;
    size_r <= size_nxt;
    boff_r <= boff_nxt;
    out_r  <= out_nxt;
  end

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_r;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_req.ready)
    else $error("ready outside idle");
  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result outside output state");
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status == ST_OK || out_r.status == ST_NO_SPACE ||
                     out_r.status == ST_BAD_FREE))
    else $error("bad status");
  a_ok_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_OK) |-> (out_r.granted_order <= ORDER_W'(MAXO)))
    else $error("order beyond max");
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (state_r == S_SIZE || state_r == S_FRD))
    else $error("accept did not start work");

endmodule

[dv/buddy_block_allocator_unit_test.sv]
// self-checking testbench for the buddy block allocator unit
module buddy_block_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int UNIT_BYTES = 64;
  localparam int POOL_UNITS = 1024;
  localparam int MAX_ORDER  = 10;
  localparam int SPAN       = 1 << MAX_ORDER;

  logic clk;
  logic rst_n;
  bba_req_if in_req();
  bba_rsp_if out_rsp();

  buddy_block_allocator_unit #(
    .UNIT_BYTES(UNIT_BYTES),
    .POOL_UNITS(POOL_UNITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(in_req.sink),
    .out_rsp(out_rsp.source)
  );

  // shadow copy of the header memory
  logic [3:0] shadow_order [SPAN];
  bit         shadow_used  [SPAN];

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  logic [OFFS_W-1:0] live_blocks [$];
  logic [OFFS_W-1:0] last_freed;

  int  accepted_reqs;
  int  checked_rsps;
  int  errors;
  int  n_alloc_ok, n_no_space, n_bad_free, n_free_ok;
  bit  stall_done;

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // first free head of a given order, or -1
  function automatic int find_free_head(int ord);
    int i;
    int step;
    i = 0;
    while (i < SPAN) begin
      if (shadow_order[i] == ord && !shadow_used[i]) return i;
      step = (shadow_order[i] > ord) ? shadow_order[i] : ord;
      if (step > MAX_ORDER) step = MAX_ORDER;
      i += 1 << step;
    end
    return -1;
  endfunction

  // apply one request to the shadow headers and return its result
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int k;
    int o;
    int head;
    int idx;
    int bud;
    int lo;
    int hi;
    logic [OFFS_W-1:0] boff;
    res = '0;
    if (r.operation == OP_ALLOC) begin
      k = 0;
      while (k <= MAX_ORDER && (longint'(UNIT_BYTES) << k) < r.request_size) k++;
      head = -1;
      o = k;
      if (k <= MAX_ORDER) begin
        for (o = k; o <= MAX_ORDER; o++) begin
          head = find_free_head(o);
          if (head >= 0) break;
        end
      end
      if (head < 0) begin
        res.status = ST_NO_SPACE;
      end else begin
        // split down, keeping the lower half
        while (o > k) begin
          o--;
          shadow_order[head] = 4'(o);
          shadow_order[head + (1 << o)] = 4'(o);
          shadow_used[head + (1 << o)] = 1'b0;
        end
        shadow_used[head] = 1'b1;
        res.status = ST_OK;
        res.granted_offset = OFFS_W'(head * UNIT_BYTES);
        res.granted_order = ORDER_W'(k);
      end
    end else begin
      boff = r.block_offset;
      idx = boff / UNIT_BYTES;
      if ((boff % UNIT_BYTES) != 0 || idx >= SPAN || !shadow_used[idx]) begin
        res.status = ST_BAD_FREE;
      end else begin
        shadow_used[idx] = 1'b0;
        // merge with free buddies of equal order
        forever begin
          o = shadow_order[idx];
          if (o >= MAX_ORDER) break;
          bud = idx ^ (1 << o);
          if (shadow_used[bud] || shadow_order[bud] != o) break;
          lo = (idx < bud) ? idx : bud;
          hi = (idx < bud) ? bud : idx;
          shadow_order[lo] = 4'(o + 1);
          shadow_order[hi] = 4'd0;
          shadow_used[hi] = 1'b0;
          idx = lo;
        end
        res.status = ST_OK;
        res.granted_offset = OFFS_W'(idx * UNIT_BYTES);
        res.granted_order = shadow_order[idx];
      end
    end
    return res;
  endfunction

  // queue a request and its predicted result, tracking live blocks
  task automatic add_request(logic op, logic [SIZE_W-1:0] size, logic [OFFS_W-1:0] offs);
    req_t r;
    rsp_t res;
    r.operation = op;
    r.request_size = size;
    r.block_offset = offs;
    res = apply_request(r);
    if (op == OP_ALLOC && res.status == ST_OK) live_blocks.push_back(res.granted_offset);
    case (res.status)
      ST_NO_SPACE: n_no_space++;
      ST_BAD_FREE: n_bad_free++;
      default: if (op == OP_ALLOC) n_alloc_ok++; else n_free_ok++;
    endcase
    pending_reqs.push_back(r);
    expected_rsps.push_back(res);
  endtask

  task automatic free_random_live();
    int pick;
    pick = $urandom_range(0, live_blocks.size() - 1);
    last_freed = live_blocks[pick];
    live_blocks.delete(pick);
    add_request(OP_FREE, SIZE_W'($urandom), last_freed);
  endtask

  function automatic logic [SIZE_W-1:0] random_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return '0;
    if (sel < 50) return SIZE_W'($urandom_range(1, UNIT_BYTES));
    if (sel < 85) return SIZE_W'($urandom_range(UNIT_BYTES + 1, 4096));
    if (sel < 97) return SIZE_W'($urandom_range(4097, 65536));
    return SIZE_W'($urandom_range(65537, 131071));
  endfunction

  // stimulus: directed corners, then random alloc/free traffic
  initial begin
    int sel;
    for (int i = 0; i < SPAN; i++) begin
      shadow_order[i] = 0;
      shadow_used[i] = 1'b0;
    end
    shadow_order[0] = MAX_ORDER;
    last_freed = '0;

    add_request(OP_ALLOC, 17'd0, 16'hFFFF);
    add_request(OP_ALLOC, 17'd64, 16'h0000);
    add_request(OP_ALLOC, 17'd65, 16'h0000);
    add_request(OP_ALLOC, 17'd65536, 16'h0000);
    add_request(OP_ALLOC, 17'd65537, 16'h0000);
    add_request(OP_ALLOC, 17'h1FFFF, 16'h0000);
    add_request(OP_ALLOC, 17'd32768, 16'h0000);
    add_request(OP_FREE, 17'h1FFFF, 16'hFFFF);
    add_request(OP_FREE, 17'd0, 16'hFFC0);
    add_request(OP_FREE, 17'd0, 16'h0040);
    while (live_blocks.size() > 0) free_random_live();
    add_request(OP_FREE, 17'd0, last_freed);
    add_request(OP_ALLOC, 17'd65536, 16'h0000);
    add_request(OP_ALLOC, 17'd1, 16'h0000);
    while (live_blocks.size() > 0) free_random_live();

    // random part, with periodic fill and drain phases
    while (pending_reqs.size() + accepted_reqs < 1350) begin
      sel = $urandom_range(0, 99);
      if ((pending_reqs.size() + accepted_reqs) % 300 > 270) begin
        if (live_blocks.size() > 0) free_random_live();
        else add_request(OP_ALLOC, random_size(), OFFS_W'($urandom));
      end else if (sel < 3) begin
        add_request(OP_FREE, SIZE_W'($urandom), OFFS_W'($urandom));
      end else if (sel < 5) begin
        add_request(OP_FREE, SIZE_W'($urandom), last_freed);
      end else if (sel < 7) begin
        add_request(OP_FREE, SIZE_W'($urandom),
                    OFFS_W'($urandom_range(0, SPAN - 1) * UNIT_BYTES));
      end else if (live_blocks.size() > 0 &&
                   sel < ((live_blocks.size() > 30) ? 60 : 40)) begin
        free_random_live();
      end else begin
        add_request(OP_ALLOC, random_size(), OFFS_W'($urandom));
      end
    end
  end

  // request driver with random gaps
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      in_req.data <= '0;
      send_gap <= 0;
    end else begin
      if (in_req.valid && in_req.ready) accepted_reqs <= accepted_reqs + 1;
      if (!in_req.valid || in_req.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_req.data <= pending_reqs.pop_front();
          in_req.valid <= 1'b1;
          if ($urandom_range(0, 9) < 7) send_gap <= 0;
          else if ($urandom_range(0, 19) == 0) send_gap <= $urandom_range(20, 60);
          else send_gap <= $urandom_range(1, 4);
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stalls, one long hold-off
  int hold_cycles;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      hold_cycles <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && accepted_reqs >= 400) begin
      stall_done <= 1'b1;
      hold_cycles <= 500;
      out_rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_rsp.ready <= 1'b0;
    end else if ($urandom_range(0, 9) < 7) begin
      out_rsp.ready <= 1'b1;
    end else begin
      out_rsp.ready <= 1'b0;
      if ($urandom_range(0, 19) == 0) hold_cycles <= $urandom_range(20, 60);
      else hold_cycles <= $urandom_range(0, 3);
    end
  end

  // result checker
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, out_rsp.data);
        errors++;
      end else begin
        want = expected_rsps.pop_front();
        checked_rsps++;
        if (out_rsp.data.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status,
                   out_rsp.data.status);
          errors++;
        end
        if (out_rsp.data.granted_offset !== want.granted_offset) begin
          $display("%0t: granted_offset expected %0h got %0h", $time,
                   want.granted_offset, out_rsp.data.granted_offset);
          errors++;
        end
        if (out_rsp.data.granted_order !== want.granted_order) begin
          $display("%0t: granted_order expected %0d got %0d", $time,
                   want.granted_order, out_rsp.data.granted_order);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    accepted_reqs = 0;
    checked_rsps = 0;
    errors = 0;
    @(posedge rst_n);
    repeat (2) @(posedge clk);
    wait (pending_reqs.size() == 0 && !in_req.valid && expected_rsps.size() == 0);
    repeat (200) @(posedge clk);
    $display("checked %0d results: %0d grants, %0d no-space, %0d merges/frees, %0d bad frees",
             checked_rsps, n_alloc_ok, n_no_space, n_free_ok, n_bad_free);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS buddy_block_allocator_unit");
    end else begin
      $display("FAIL buddy_block_allocator_unit");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1s;
    $display("FAIL buddy_block_allocator_unit");
    $finish;
  end

endmodule
